FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLY(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/core/lier_pkg.sv
`timescale 1ns / 1ps
package lier_pkg;

    localparam int NUM_LAYERS     = 8;
    localparam int CAPS_PER_LAYER = 8;
    localparam int NUM_OWNERS     = 16;
    localparam int KEY_BITS       = 10;

    localparam int LAYER_W    = $clog2(NUM_LAYERS);
    localparam int CAP_IDX_W  = $clog2(CAPS_PER_LAYER);
    localparam int CAP_CNT_W  = $clog2(CAPS_PER_LAYER + 1);
    localparam int CAP_DEPTH  = NUM_LAYERS * CAPS_PER_LAYER;
    localparam int CAP_ADDR_W = LAYER_W + CAP_IDX_W;
    localparam int OWN_IDX_W  = $clog2(NUM_OWNERS);
    localparam int OWN_CNT_W  = $clog2(NUM_OWNERS + 1);

    typedef enum logic [1:0] {
        OP_ROUTE  = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_SET    = 2'd3
    } op_t;

    localparam logic [1:0] EV_PRESS   = 2'd0;
    localparam logic [1:0] EV_RELEASE = 2'd1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CAP_FULL = 2'd1;
    localparam logic [1:0] ST_DROPPED  = 2'd2;
    localparam logic [1:0] ST_OWN_FULL = 2'd3;

    localparam logic KIND_PASS = 1'b1;
    localparam logic MODE_ANY  = 1'b1;

    typedef struct packed {
        logic [1:0]          operation;
        logic [2:0]          layer;
        logic [KEY_BITS-1:0] key;
        logic                match_mode;
        logic                capture_kind;
        logic [1:0]          event_kind;
        logic signed [7:0]   priority_req;
        logic                live;
    } req_t;

    typedef struct packed {
        logic       delivered;
        logic [2:0] dest_layer;
        logic       used_kind;
        logic       used_mode;
        logic [1:0] status;
        logic       last;
    } res_t;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic                mode;
        logic                kind;
    } cap_ent_t;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [LAYER_W-1:0]  layer;
        logic                mode;
        logic                kind;
    } own_ent_t;

endpackage

FILE: rtl/core/lier_ram.sv
`timescale 1ns / 1ps
module lier_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

FILE: rtl/core/layered_input_event_router_top.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Layered key-event router. One request in, one to eight results out, the last
// one flagged. A small sequencer drives one shared key comparator over two
// RAMs with one write and one read port (capture lists, 64 x 12; key owners,
// 16 x 15) and one signed priority comparator over the layer registers. The
// block takes no new request until the last result of the current one sits in
// the output register. Steps per request: set layer writes the layer registers;
// add/remove walk the stored captures of the layer; a route runs layer
// selection passes (one layer per cycle through the priority comparator, up to
// 9 passes), checks captures, and walks the owner table when a release looks
// up its owner or a consumed press rewrites the owner table. Captured/owner
// RAMs need no clearing pass: entries are only read below their fill counts.
module layered_input_event_router_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  lier_pkg::req_t req_data,
    output logic          res_valid,
    input  logic          res_ready,
    output lier_pkg::res_t res_data
);
    import lier_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_CAP_RD  = 9'b000000010,
        S_CAP_CHK = 9'b000000100,
        S_CAP_END = 9'b000001000,
        S_OWN_RD  = 9'b000010000,
        S_OWN_CHK = 9'b000100000,
        S_OWN_END = 9'b001000000,
        S_SEL     = 9'b010000000,
        S_OUT     = 9'b100000000
    } state_t;

    // control state
    state_t                state_reg, state_next;
    logic [CAP_CNT_W-1:0]  cap_count_reg [NUM_LAYERS];
    logic [CAP_CNT_W-1:0]  cap_count_next [NUM_LAYERS];
    logic signed [7:0]     prio_reg [NUM_LAYERS];
    logic signed [7:0]     prio_next [NUM_LAYERS];
    logic [NUM_LAYERS-1:0] alive_reg, alive_next;
    logic [OWN_CNT_W-1:0]  own_count_reg, own_count_next;
    logic [NUM_LAYERS-1:0] visited_reg, visited_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  best_valid_reg, best_valid_next;
    logic                  found_reg, found_next;

    // payload
    op_t                   op_reg, op_next;
    logic [LAYER_W-1:0]    layer_reg, layer_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic                  mode_reg, mode_next;
    logic                  kind_reg, kind_next;
    logic [1:0]            ev_reg, ev_next;
    logic [LAYER_W-1:0]    cur_reg, cur_next;
    logic [LAYER_W-1:0]    sidx_reg, sidx_next;
    logic [LAYER_W-1:0]    best_reg, best_next;
    logic signed [7:0]     best_prio_reg, best_prio_next;
    logic [CAP_CNT_W-1:0]  cidx_reg, cidx_next;
    logic [CAP_CNT_W-1:0]  cwr_reg, cwr_next;
    logic [OWN_CNT_W-1:0]  oidx_reg, oidx_next;
    logic [OWN_CNT_W-1:0]  owr_reg, owr_next;
    own_ent_t              fnd_reg, fnd_next;
    res_t                  pend_reg, pend_next;
    res_t                  out_reg, out_next;

    // RAM ports
    logic                  cw_en, cr_en, ow_en, or_en;
    logic [CAP_ADDR_W-1:0] cw_addr, cr_addr;
    cap_ent_t              cw_data, cr_data;
    logic [OWN_IDX_W-1:0]  ow_addr, or_addr;
    own_ent_t              ow_data, or_data;

    lier_ram #(.WIDTH($bits(cap_ent_t)), .DEPTH(CAP_DEPTH)) u_cap_ram (
        .clk(clk), .wr_en(cw_en), .wr_addr(cw_addr), .wr_data(cw_data),
        .rd_en(cr_en), .rd_addr(cr_addr), .rd_data(cr_data)
    );

    lier_ram #(.WIDTH($bits(own_ent_t)), .DEPTH(NUM_OWNERS)) u_own_ram (
        .clk(clk), .wr_en(ow_en), .wr_addr(ow_addr), .wr_data(ow_data),
        .rd_en(or_en), .rd_addr(or_addr), .rd_data(or_data)
    );

    logic                  out_free;
    logic                  push;
    logic [LAYER_W-1:0]    lay;
    logic [LAYER_W-1:0]    cc_addr;
    logic [CAP_CNT_W-1:0]  cc_val;
    logic [LAYER_W-1:0]    al_addr;
    logic                  al_val;
    logic                  key_eq;
    logic                  better;
    logic                  nb_valid;
    logic [LAYER_W-1:0]    nb_idx;
    logic [CAP_CNT_W-1:0]  cidx_inc;
    logic [OWN_CNT_W-1:0]  oidx_inc;
    logic                  cap_hit;
    logic                  own_drop;
    res_t                  res_new;

    assign out_free  = !out_valid_reg || res_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

    assign lay      = (op_reg == OP_ROUTE) ? cur_reg : layer_reg;
    assign cidx_inc = cidx_reg + 1'b1;
    assign oidx_inc = oidx_reg + 1'b1;

    // shared key comparator: capture RAM or owner RAM, by state
    assign key_eq = (state_reg == S_OWN_CHK) ? (or_data.key == key_reg)
                                             : (cr_data.key == key_reg);

    // shared signed priority comparator for the layer selection pass
    assign better   = alive_reg[sidx_reg] && !visited_reg[sidx_reg] &&
                      (!best_valid_reg || (prio_reg[sidx_reg] > best_prio_reg));
    assign nb_valid = best_valid_reg || better;
    assign nb_idx   = better ? sidx_reg : best_reg;

    // single read port on the count registers; the live bits have a second read in the comparator
    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  cc_addr = req_data.layer;
            S_SEL:   cc_addr = nb_idx;
            default: cc_addr = lay;
        endcase
    end
    assign cc_val  = cap_count_reg[cc_addr];
    assign al_addr = (state_reg == S_OWN_END) ? fnd_reg.layer : sidx_reg;
    assign al_val  = alive_reg[al_addr];

    assign cap_hit  = (op_reg == OP_ROUTE) ? (cr_data.mode == MODE_ANY || key_eq)
                                           : (cr_data.mode == mode_reg && key_eq);
    assign own_drop = key_eq && (ev_reg == EV_PRESS || !found_reg);

    always_comb
    begin
        res_new            = '0;
        res_new.delivered  = 1'b1;
        res_new.dest_layer = cur_reg;
        res_new.used_kind  = cr_data.kind;
        res_new.used_mode  = cr_data.mode;
        res_new.status     = ST_OK;
    end

    always_comb
    begin
        state_next      = state_reg;
        cap_count_next  = cap_count_reg;
        prio_next       = prio_reg;
        alive_next      = alive_reg;
        own_count_next  = own_count_reg;
        visited_next    = visited_reg;
        pend_valid_next = pend_valid_reg;
        best_valid_next = best_valid_reg;
        found_next      = found_reg;
        op_next         = op_reg;
        layer_next      = layer_reg;
        key_next        = key_reg;
        mode_next       = mode_reg;
        kind_next       = kind_reg;
        ev_next         = ev_reg;
        cur_next        = cur_reg;
        sidx_next       = sidx_reg;
        best_next       = best_reg;
        best_prio_next  = best_prio_reg;
        cidx_next       = cidx_reg;
        cwr_next        = cwr_reg;
        oidx_next       = oidx_reg;
        owr_next        = owr_reg;
        fnd_next        = fnd_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        push            = 1'b0;
        cw_en           = 1'b0;
        cw_addr         = {lay, cidx_reg[CAP_IDX_W-1:0]};
        cw_data         = cr_data;
        cr_en           = 1'b0;
        cr_addr         = {lay, cidx_reg[CAP_IDX_W-1:0]};
        ow_en           = 1'b0;
        ow_addr         = owr_reg[OWN_IDX_W-1:0];
        ow_data         = or_data;
        or_en           = 1'b0;
        or_addr         = oidx_reg[OWN_IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next        = op_t'(req_data.operation);
                    layer_next     = req_data.layer;
                    key_next       = req_data.key;
                    mode_next      = req_data.match_mode;
                    kind_next      = req_data.capture_kind;
                    ev_next        = req_data.event_kind;
                    cidx_next      = '0;
                    cwr_next       = '0;
                    oidx_next      = '0;
                    owr_next       = '0;
                    found_next     = 1'b0;
                    visited_next   = '0;
                    sidx_next      = '0;
                    best_valid_next = 1'b0;
                    pend_next      = '0;
                    pend_next.dest_layer = req_data.layer;
                    pend_valid_next = (op_t'(req_data.operation) != OP_ROUTE);
                    unique case (op_t'(req_data.operation))
                        OP_ROUTE:
                        begin
                            if (req_data.event_kind == EV_RELEASE && own_count_reg != '0)
                                state_next = S_OWN_RD;
                            else
                                state_next = S_SEL;
                        end
                        OP_ADD:
                        begin
                            state_next = (cc_val == '0) ? S_CAP_END : S_CAP_RD;
                        end
                        OP_REMOVE:
                        begin
                            state_next = (cc_val == '0) ? S_OUT : S_CAP_RD;
                        end
                        OP_SET:
                        begin
                            prio_next[req_data.layer]  = req_data.priority_req;
                            alive_next[req_data.layer] = req_data.live;
                            state_next = S_OUT;
                        end
                    endcase
                end
            end

            S_CAP_RD:
            begin
                cr_en      = 1'b1;
                state_next = S_CAP_CHK;
            end

            S_CAP_CHK:
            begin
                unique case (op_reg)
                    OP_ADD:
                    begin
                        if (cap_hit)
                        begin
                            cw_en           = 1'b1;
                            cw_data.key     = key_reg;
                            cw_data.mode    = mode_reg;
                            cw_data.kind    = kind_reg;
                            state_next      = S_OUT;
                        end
                        else
                        begin
                            cidx_next  = cidx_inc;
                            state_next = (cidx_inc < cc_val) ? S_CAP_RD : S_CAP_END;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (!cap_hit)
                        begin
                            cw_en    = 1'b1;
                            cw_addr  = {lay, cwr_reg[CAP_IDX_W-1:0]};
                            cwr_next = cwr_reg + 1'b1;
                        end
                        cidx_next = cidx_inc;
                        if (!(cidx_inc < cc_val))
                        begin
                            cap_count_next[lay] = cap_hit ? cwr_reg : cwr_reg + 1'b1;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            state_next = S_CAP_RD;
                        end
                    end
                    default:
                    begin
                        // route walk
                        if (cap_hit)
                        begin
                            if (!pend_valid_reg || out_free)
                            begin
                                if (pend_valid_reg)
                                begin
                                    push          = 1'b1;
                                    out_next      = pend_reg;
                                    out_next.last = 1'b0;
                                end
                                pend_next       = res_new;
                                pend_valid_next = 1'b1;
                                if (cr_data.kind == KIND_PASS)
                                begin
                                    sidx_next       = '0;
                                    best_valid_next = 1'b0;
                                    state_next      = S_SEL;
                                end
                                else if (ev_reg == EV_PRESS)
                                begin
                                    oidx_next  = '0;
                                    owr_next   = '0;
                                    state_next = (own_count_reg == '0) ? S_OWN_END : S_OWN_RD;
                                end
                                else
                                begin
                                    state_next = S_OUT;
                                end
                            end
                        end
                        else
                        begin
                            cidx_next = cidx_inc;
                            if (cidx_inc < cc_val)
                            begin
                                state_next = S_CAP_RD;
                            end
                            else
                            begin
                                sidx_next       = '0;
                                best_valid_next = 1'b0;
                                state_next      = S_SEL;
                            end
                        end
                    end
                endcase
            end

            S_CAP_END:
            begin
                // append after a miss, or report a full list
                if (cc_val < CAP_CNT_W'(CAPS_PER_LAYER))
                begin
                    cw_en               = 1'b1;
                    cw_addr             = {lay, cc_val[CAP_IDX_W-1:0]};
                    cw_data.key         = key_reg;
                    cw_data.mode        = mode_reg;
                    cw_data.kind        = kind_reg;
                    cap_count_next[lay] = cc_val + 1'b1;
                end
                else
                begin
                    pend_next.status = ST_CAP_FULL;
                end
                state_next = S_OUT;
            end

            S_OWN_RD:
            begin
                or_en      = 1'b1;
                state_next = S_OWN_CHK;
            end

            S_OWN_CHK:
            begin
                if (own_drop)
                begin
                    if (ev_reg != EV_PRESS)
                    begin
                        found_next = 1'b1;
                        fnd_next   = or_data;
                    end
                end
                else
                begin
                    ow_en    = 1'b1;
                    owr_next = owr_reg + 1'b1;
                end
                oidx_next = oidx_inc;
                if (oidx_inc < own_count_reg)
                begin
                    state_next = S_OWN_RD;
                end
                else
                begin
                    own_count_next = own_drop ? owr_reg : owr_reg + 1'b1;
                    state_next     = S_OWN_END;
                end
            end

            S_OWN_END:
            begin
                if (ev_reg == EV_PRESS)
                begin
                    if (own_count_reg < OWN_CNT_W'(NUM_OWNERS))
                    begin
                        ow_en          = 1'b1;
                        ow_addr        = own_count_reg[OWN_IDX_W-1:0];
                        ow_data.key    = key_reg;
                        ow_data.layer  = cur_reg;
                        ow_data.mode   = pend_reg.used_mode;
                        ow_data.kind   = pend_reg.used_kind;
                        own_count_next = own_count_reg + 1'b1;
                    end
                    else
                    begin
                        pend_next.status = ST_OWN_FULL;
                    end
                    state_next = S_OUT;
                end
                else if (found_reg)
                begin
                    pend_valid_next      = 1'b1;
                    pend_next            = '0;
                    pend_next.dest_layer = fnd_reg.layer;
                    if (al_val)
                    begin
                        pend_next.delivered = 1'b1;
                        pend_next.used_kind = fnd_reg.kind;
                        pend_next.used_mode = fnd_reg.mode;
                    end
                    else
                    begin
                        pend_next.status = ST_DROPPED;
                    end
                    state_next = S_OUT;
                end
                else
                begin
                    sidx_next       = '0;
                    best_valid_next = 1'b0;
                    state_next      = S_SEL;
                end
            end

            S_SEL:
            begin
                // one layer per cycle; strict compare keeps the lower number on ties
                best_valid_next = nb_valid;
                best_next       = nb_idx;
                if (better)
                    best_prio_next = prio_reg[sidx_reg];
                sidx_next = sidx_reg + 1'b1;
                if (sidx_reg == LAYER_W'(NUM_LAYERS - 1))
                begin
                    sidx_next       = '0;
                    best_valid_next = 1'b0;
                    if (nb_valid)
                    begin
                        cur_next             = nb_idx;
                        visited_next[nb_idx] = 1'b1;
                        cidx_next            = '0;
                        state_next           = (cc_val == '0) ? S_SEL : S_CAP_RD;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end

            S_OUT:
            begin
                if (out_free)
                begin
                    push            = 1'b1;
                    out_next        = pend_valid_reg ? pend_reg : '0;
                    out_next.last   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = push ? 1'b1 : (res_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cap_count_reg  <= '{default: '0};
            prio_reg       <= '{default: '0};
            alive_reg      <= '0;
            own_count_reg  <= '0;
            visited_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            best_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cap_count_reg  <= cap_count_next;
            prio_reg       <= prio_next;
            alive_reg      <= alive_next;
            own_count_reg  <= own_count_next;
            visited_reg    <= visited_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            best_valid_reg <= best_valid_next;
            found_reg      <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        layer_reg     <= layer_next;
        key_reg       <= key_next;
        mode_reg      <= mode_next;
        kind_reg      <= kind_next;
        ev_reg        <= ev_next;
        cur_reg       <= cur_next;
        sidx_reg      <= sidx_next;
        best_reg      <= best_next;
        best_prio_reg <= best_prio_next;
        cidx_reg      <= cidx_next;
        cwr_reg       <= cwr_next;
        oidx_reg      <= oidx_next;
        owr_reg       <= owr_next;
        fnd_reg       <= fnd_next;
        pend_reg      <= pend_next;
        out_reg       <= out_next;
    end

    // owner table never overfills
    `ASSERT_IMPLY(a_own_bound, clk, rst_n, 1'b1, own_count_reg <= OWN_CNT_W'(NUM_OWNERS))
    // results only move into a free output register
    `ASSERT_IMPLY(a_push_free, clk, rst_n, push, out_free)
    // no stale result is left over when a new request is taken
    `ASSERT_IMPLY(a_idle_clean, clk, rst_n, state_reg == S_IDLE, !pend_valid_reg)
    // the final result of a request always closes with last set
    `ASSERT_NEXT(a_out_last, clk, rst_n, state_reg == S_OUT && out_free,
                 out_valid_reg && out_reg.last)
endmodule
